>>> design/cre_pkg.sv
// shared types and constants for the clipped rectangle fill engine
// no dependencies; imported by the top level clipped_rect_fill_engine and the testbench
package cre_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;

  // clip arithmetic width: two 16-bit signed values summed never overflow this
  localparam int CLIP_W = 18;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_PLOT  = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP_LO,
    ST_CLIP_HI,
    ST_SIZE,
    ST_BASE,
    ST_ADDR,
    ST_FILL,
    ST_READ,
    ST_READ_CAP,
    ST_DONE
  } state_t;

endpackage

>>> design/cre_mul.sv
// shared registered multiplier used for the rectangle area and the row base address
// depends on nothing but its operand width parameter
module cre_mul #(
  parameter int OW = 11
) (
  input  logic            clk,
  input  logic [OW-1:0]   mul_a,
  input  logic [OW-1:0]   mul_b,
  output logic [2*OW-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

>>> design/cre_frame_mem.sv
// frame store: one write port and one registered read port
// contents are undefined until written
module cre_frame_mem #(
  parameter int DEPTH = 64000,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> design/clipped_rect_fill_engine.sv
// top level: command sequencer, clip registers, fill counters and output register
// depends on cre_pkg, cre_mul and cre_frame_mem
//
// usage:
//   a request enters on in_valid/in_ready and carries a command (plot, fill
//   rectangle, read, clear), origin, size and color. plot and read are handled
//   as a 1x1 rectangle, clear as the full screen, so every command goes
//   through the same clip, area and address steps on one shared multiplier.
//   exactly one result leaves on out_valid/out_ready per request: the read
//   byte (zero unless a read on screen) and the number of bytes written.
//   steps: clip low, clip high and size follow accept; unless clipping leaves
//   nothing, base and address, then a fill or clear at one byte per cycle
//   through the frame store's single write port, or a read and its capture.
//   one request is in work at a time; in_ready is high only when idle, in the
//   cycle after the previous result is loaded.
//   a result waiting on a stalled receiver sits in the output register and the
//   next request is accepted meanwhile; it then waits at its end until the
//   output register frees up.
//   reset clears the sequencer and the output valid and holds in_ready low;
//   the frame store is not cleared and holds undefined bytes until written.
module clipped_rect_fill_engine #(
  parameter int SCREEN_WIDTH  = cre_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cre_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_rect_width,
  input  logic signed [15:0] in_rect_height,
  input  logic [7:0]         in_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_pixel_value,
  output logic [15:0]        out_pixels_written
);

  import cre_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(SCREEN_WIDTH + 1);
  localparam int YW    = $clog2(SCREEN_HEIGHT + 1);
  localparam int OW    = (XW > YW) ? XW : YW;
  localparam int PW    = 2 * OW;

  localparam logic signed [CLIP_W-1:0] SW_S = CLIP_W'(SCREEN_WIDTH);
  localparam logic signed [CLIP_W-1:0] SH_S = CLIP_W'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]            SW_A = AW'(SCREEN_WIDTH);

  state_t state_r, state_nxt;

  req_t                      kind_r;
  logic [7:0]                color_r;
  logic signed [CLIP_W-1:0]  x_r, y_r, w_r, h_r;
  logic [7:0]                value_r;
  logic [15:0]               count_r;
  logic [AW-1:0]             addr_r, row_base_r;
  logic [XW-1:0]             col_r;
  logic [YW-1:0]             row_r;

  logic        out_valid_r;
  logic [7:0]  out_pixel_value_r;
  logic [15:0] out_pixels_written_r;

  logic [OW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod_r;
  logic [7:0]    rd_data_r;

  logic accept, empty, col_last, row_last, out_load;
  logic wr_en, rd_en;

  assign accept   = in_valid && in_ready;
  // nonpositive width or height after clipping
  assign empty    = w_r[CLIP_W-1] || (w_r == '0) || h_r[CLIP_W-1] || (h_r == '0);
  assign col_last = (col_r == (w_r[XW-1:0] - XW'(1)));
  assign row_last = (row_r == (h_r[YW-1:0] - YW'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CLIP_LO;
      ST_CLIP_LO:  state_nxt = ST_CLIP_HI;
      ST_CLIP_HI:  state_nxt = ST_SIZE;
      ST_SIZE:     state_nxt = empty ? ST_DONE : ST_BASE;
      ST_BASE:     state_nxt = ST_ADDR;
      ST_ADDR:     state_nxt = (kind_r == REQ_READ) ? ST_READ : ST_FILL;
      ST_FILL:     if (col_last && row_last) state_nxt = ST_DONE;
      ST_READ:     state_nxt = ST_READ_CAP;
      ST_READ_CAP: state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    mul_a    = w_r[OW-1:0];
    mul_b    = h_r[OW-1:0];
    unique case (state_r)
      ST_IDLE:  in_ready = rst_n;
      ST_BASE: begin
        mul_a = y_r[OW-1:0];
        mul_b = OW'(SCREEN_WIDTH);
      end
      ST_FILL:  wr_en = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_DONE:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_r  <= req_t'(in_req_type);
          color_r <= in_color;
          value_r <= '0;
          count_r <= '0;
          case (req_t'(in_req_type))
            REQ_CLEAR: begin
              x_r <= '0;
              y_r <= '0;
              w_r <= SW_S;
              h_r <= SH_S;
            end
            REQ_FILL: begin
              x_r <= CLIP_W'(in_pos_x);
              y_r <= CLIP_W'(in_pos_y);
              w_r <= CLIP_W'(in_rect_width);
              h_r <= CLIP_W'(in_rect_height);
            end
            default: begin
              x_r <= CLIP_W'(in_pos_x);
              y_r <= CLIP_W'(in_pos_y);
              w_r <= CLIP_W'(1);
              h_r <= CLIP_W'(1);
            end
          endcase
        end
      end
      ST_CLIP_LO: begin
        // negative origin eats into the size
        if (x_r[CLIP_W-1]) begin
          w_r <= w_r + x_r;
          x_r <= '0;
        end
        if (y_r[CLIP_W-1]) begin
          h_r <= h_r + y_r;
          y_r <= '0;
        end
      end
      ST_CLIP_HI: begin
        if ((x_r + w_r) > SW_S) w_r <= SW_S - x_r;
        if ((y_r + h_r) > SH_S) h_r <= SH_S - y_r;
      end
      ST_BASE: begin
        if (kind_r != REQ_READ) begin
          count_r <= (32'(prod_r) > 32'(COUNT_MAX)) ? COUNT_MAX : 16'(prod_r);
        end
      end
      ST_ADDR: begin
        addr_r     <= AW'(prod_r) + AW'(x_r[OW-1:0]);
        row_base_r <= AW'(prod_r) + AW'(x_r[OW-1:0]);
        col_r      <= '0;
        row_r      <= '0;
      end
      ST_FILL: begin
        if (col_last) begin
          col_r      <= '0;
          row_r      <= row_r + YW'(1);
          row_base_r <= row_base_r + SW_A;
          addr_r     <= row_base_r + SW_A;
        end else begin
          col_r  <= col_r + XW'(1);
          addr_r <= addr_r + AW'(1);
        end
      end
      ST_READ_CAP: value_r <= rd_data_r;
      default: ;
    endcase
  end

  // output register, frees the input side while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_value_r    <= value_r;
      out_pixels_written_r <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_value    = out_pixel_value_r;
  assign out_pixels_written = out_pixels_written_r;

  cre_mul #(
    .OW (OW)
  ) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  cre_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (addr_r),
    .wr_data   (color_r),
    .rd_en     (rd_en),
    .rd_addr   (addr_r),
    .rd_data_r (rd_data_r)
  );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for clipped_rect_fill_engine: directed table, then random commands
// keeps a shadow frame store to predict every result; depends on cre_pkg and the design
module tb_top;
  import cre_pkg::*;

  localparam int SW = SCREEN_WIDTH_DEF;
  localparam int SH = SCREEN_HEIGHT_DEF;
  localparam int FRAME_BYTES = SW * SH;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 575;
  localparam int QUIET_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int FIRST_HOLD_AT = 300;
  localparam int HOLD_SPACING = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] count;
  } frame_result_t;

  typedef struct packed {
    req_t        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  color;
    logic        typed;
    logic [7:0]  want_value;
    logic [15:0] want_count;
  } draw_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = REQ_PLOT;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [15:0] in_rect_width = '0;
  logic signed [15:0] in_rect_height = '0;
  logic [7:0]         in_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_pixel_value;
  logic [15:0]        out_pixels_written;

  logic [7:0]    shadow_frame [FRAME_BYTES];
  frame_result_t pending_results [$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;
  int            tx_idle_pct = 6;
  int            rx_idle_pct = 85;
  int            tx_idle_by_phase [3] = '{6, 85, 0};
  int            rx_idle_by_phase [3] = '{85, 6, 0};

  // directed commands; typed rows carry a result readable by eye, the rest use the shadow store
  draw_row_t directed_rows [25] = '{
    '{REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b1, 8'h00, 16'd64000},
    '{REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b1, 8'hFF, 16'd0},
    '{REQ_READ, 16'd319, 16'd199, 16'h7FFF, 16'h8000, 8'h00, 1'b1, 8'hFF, 16'd0},
    '{REQ_PLOT, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 1'b1, 8'h00, 16'd1},
    '{REQ_PLOT, 16'd319, 16'd199, 16'd0, 16'd0, 8'h5A, 1'b1, 8'h00, 16'd1},
    '{REQ_PLOT, 16'd320, 16'd0, 16'd0, 16'd0, 8'h11, 1'b1, 8'h00, 16'd0},
    '{REQ_PLOT, 16'hFFFF, 16'd5, 16'd0, 16'd0, 8'h22, 1'b1, 8'h00, 16'd0},
    '{REQ_PLOT, 16'd5, 16'd200, 16'd0, 16'd0, 8'h33, 1'b1, 8'h00, 16'd0},
    '{REQ_PLOT, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 8'h44, 1'b1, 8'h00, 16'd0},
    '{REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 8'hFF, 1'b1, 8'h00, 16'd0},
    '{REQ_READ, 16'd319, 16'd199, 16'd0, 16'd0, 8'h00, 1'b1, 8'h5A, 16'd0},
    '{REQ_READ, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'h00, 1'b1, 8'h00, 16'd0},
    '{REQ_READ, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 8'h00, 1'b1, 8'h00, 16'd0},
    '{REQ_FILL, 16'hFFFB, 16'hFFFD, 16'd10, 16'd8, 8'h3C, 1'b0, 8'h00, 16'd0},
    '{REQ_FILL, 16'd315, 16'd197, 16'd20, 16'd20, 8'hC3, 1'b0, 8'h00, 16'd0},
    '{REQ_FILL, 16'd10, 16'd10, 16'd0, 16'd5, 8'h77, 1'b1, 8'h00, 16'd0},
    '{REQ_FILL, 16'd10, 16'd10, 16'h8000, 16'h8000, 8'h77, 1'b1, 8'h00, 16'd0},
    '{REQ_FILL, 16'hFF9C, 16'hFF9C, 16'd50, 16'd50, 8'h77, 1'b1, 8'h00, 16'd0},
    '{REQ_FILL, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'h77, 1'b1, 8'h00, 16'd0},
    '{REQ_FILL, 16'd0, 16'd100, 16'h7FFF, 16'd1, 8'hA5, 1'b0, 8'h00, 16'd0},
    '{REQ_FILL, 16'd100, 16'd50, 16'd4, 16'd3, 8'h81, 1'b0, 8'h00, 16'd0},
    '{REQ_READ, 16'd2, 16'd1, 16'd0, 16'd0, 8'h00, 1'b0, 8'h00, 16'd0},
    '{REQ_READ, 16'd319, 16'd199, 16'd0, 16'd0, 8'h00, 1'b0, 8'h00, 16'd0},
    '{REQ_READ, 16'd103, 16'd52, 16'd0, 16'd0, 8'h00, 1'b0, 8'h00, 16'd0},
    '{REQ_READ, 16'd150, 16'd100, 16'd0, 16'd0, 8'h00, 1'b0, 8'h00, 16'd0}
  };

  clipped_rect_fill_engine #(
    .SCREEN_WIDTH(SW),
    .SCREEN_HEIGHT(SH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_rect_width(in_rect_width),
    .in_rect_height(in_rect_height),
    .in_color(in_color),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_value(out_pixel_value),
    .out_pixels_written(out_pixels_written)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit on_screen(input int x, input int y);
    return x >= 0 && x < SW && y >= 0 && y < SH;
  endfunction

  // updates the shadow store and returns what the block should answer
  function automatic frame_result_t draw_and_predict(input req_t kind, input int x, input int y,
                                                     input int w, input int h,
                                                     input logic [7:0] col);
    frame_result_t res;
    int n;
    res = '0;
    n = 0;
    case (kind)
      REQ_PLOT: begin
        if (on_screen(x, y)) begin
          shadow_frame[y * SW + x] = col;
          n = 1;
        end
      end
      REQ_FILL: begin
        if (x < 0) begin
          w = w + x;
          x = 0;
        end
        if (y < 0) begin
          h = h + y;
          y = 0;
        end
        if (x + w > SW) w = SW - x;
        if (y + h > SH) h = SH - y;
        if (w > 0 && h > 0) begin
          for (int r = 0; r < h; r++) begin
            for (int k = 0; k < w; k++) begin
              shadow_frame[(y + r) * SW + x + k] = col;
            end
          end
          n = w * h;
        end
      end
      REQ_READ: begin
        if (on_screen(x, y)) res.value = shadow_frame[y * SW + x];
      end
      default: begin
        foreach (shadow_frame[i]) shadow_frame[i] = col;
        n = FRAME_BYTES;
      end
    endcase
    res.count = (n > int'(COUNT_MAX)) ? COUNT_MAX : 16'(n);
    return res;
  endfunction

  function automatic logic [15:0] rim_coord(input int span);
    case ($urandom_range(3))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'(span - 1);
      default: return 16'(span);
    endcase
  endfunction

  task automatic send_request(input req_t kind, input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] rw, input logic [15:0] rh,
                              input logic [7:0] col, input logic typed,
                              input logic [7:0] want_value, input logic [15:0] want_count);
    frame_result_t want;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_pos_x       <= px;
    in_pos_y       <= py;
    in_rect_width  <= rw;
    in_rect_height <= rh;
    in_color       <= col;
    do @(posedge clk); while (!in_ready);
    want = draw_and_predict(kind, int'($signed(px)), int'($signed(py)), int'($signed(rw)),
                            int'($signed(rh)), col);
    if (typed) begin
      want.value = want_value;
      want.count = want_count;
    end
    pending_results.push_back(want);
  endtask

  // mostly well-formed on-screen work, with clipped edges, off-screen noise and rare clears
  task automatic pick_random_request(output req_t kind, output logic [15:0] px,
                                     output logic [15:0] py, output logic [15:0] rw,
                                     output logic [15:0] rh, output logic [7:0] col);
    int pick;
    pick = $urandom_range(999);
    kind = REQ_PLOT;
    px = 16'($urandom_range(SW - 1));
    py = 16'($urandom_range(SH - 1));
    rw = 16'($urandom);
    rh = 16'($urandom);
    col = 8'($urandom);
    if (pick < 2) begin
      kind = REQ_CLEAR;
    end else if (pick < 260) begin
      kind = REQ_PLOT;
    end else if (pick < 520) begin
      kind = REQ_READ;
    end else if (pick < 800) begin
      kind = REQ_FILL;
      px = 16'(int'($urandom_range(SW + 34)) - 24);
      py = 16'(int'($urandom_range(SH + 34)) - 24);
      if ($urandom_range(49) == 0) begin
        rw = 16'($urandom_range(SW + 10));
        rh = 16'($urandom_range(SH + 10));
      end else begin
        rw = 16'(int'($urandom_range(27)) - 3);
        rh = 16'(int'($urandom_range(27)) - 3);
      end
    end else if (pick < 880) begin
      kind = $urandom_range(1) ? REQ_READ : REQ_PLOT;
      px = 16'($urandom);
      py = 16'($urandom);
    end else if (pick < 890) begin
      // full-range rectangle, usually clipped away entirely
      kind = REQ_FILL;
      px = 16'($urandom);
      py = 16'($urandom);
    end else begin
      case ($urandom_range(2))
        0: kind = REQ_PLOT;
        1: kind = REQ_READ;
        default: kind = REQ_FILL;
      endcase
      px = rim_coord(SW);
      py = rim_coord(SH);
      rw = 16'(int'($urandom_range(4)) - 1);
      rh = 16'(int'($urandom_range(4)) - 1);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected result: value %02h count %0d", out_pixel_value,
                   out_pixels_written);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_pixel_value !== want.value || out_pixels_written !== want.count) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch on result %0d: expected value %02h count %0d, got value %02h count %0d",
                     results_seen, want.value, want.count, out_pixel_value, out_pixels_written);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("clipped_rect_fill_engine regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver; a long hold-off now and then backs the block up into its input
  initial begin : result_sink
    int hold_left;
    int next_hold_at;
    hold_left = 0;
    next_hold_at = FIRST_HOLD_AT;
    forever begin
      @(posedge clk);
      if (rst_n && results_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at = next_hold_at + HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    req_t kind;
    logic [15:0] px, py, rw, rh;
    logic [7:0] col;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // the opening clear writes every byte, so later reads never see an unwritten one
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].w, directed_rows[i].h, directed_rows[i].color,
                   directed_rows[i].typed, directed_rows[i].want_value,
                   directed_rows[i].want_count);
    end
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_idle_by_phase[phase];
      rx_idle_pct = rx_idle_by_phase[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_random_request(kind, px, py, rw, rh, col);
        send_request(kind, px, py, rw, rh, col, 1'b0, 8'h00, 16'd0);
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("clipped_rect_fill_engine regression: pass");
    end else begin
      $display("clipped_rect_fill_engine regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/cre_pkg.sv
design/cre_mul.sv
design/cre_frame_mem.sv
design/clipped_rect_fill_engine.sv
tb/tb_top.sv
